// ----- src/pbrd_pkg.sv -----
// pbrd_pkg: types and constants shared by the pulse beat rate detector
// holds payload structs, controller/datapath command and status types
// no dependencies
package pbrd_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WIN_MS_W = 10;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned WSUM_W   = 26;
  localparam int unsigned WCNT_W   = 16;
  localparam int unsigned MEAN_W   = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned RATE_W   = 16;

  // shared divider: 32-bit dividend, 36-bit divisor
  localparam int unsigned DIV_N_W  = 32;
  localparam int unsigned DIV_D_W  = 36;
  localparam int unsigned PAIR3_W  = 35;

  localparam logic [DIV_N_W-1:0]  RATE_NUM  = 32'd6000000;
  localparam logic [WCNT_W-1:0]   COUNT_MAX = 16'hFFFF;
  localparam logic [LIMIT_W-1:0]  RISE_MAX  = 8'hFF;
  localparam logic [RATE_W-1:0]   RATE_MAX  = 16'hFFFF;

  localparam logic [WIN_MS_W-1:0] WIN_MS_RESET  = 10'd20;
  localparam logic [LIMIT_W-1:0]  RISE_LIM_RESET = 8'd4;

  // register index decoded from paddr[2]
  localparam logic REG_WINDOW_MS  = 1'b0;
  localparam logic REG_RISE_LIMIT = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
    logic [TIME_W-1:0]   time_ms;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] smoothed_level;
    logic               curve_rising;
    logic               beat_found;
    logic [RATE_W-1:0]  rate_tenths_bpm;
  } out_item_t;

  typedef struct packed {
    logic [WIN_MS_W-1:0] window_ms;
    logic [LIMIT_W-1:0]  rise_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_RATE
  } div_op_e;

  typedef struct packed {
    logic    take_in;
    logic    div_start;
    div_op_e div_op;
    logic    hist_upd;
    logic    prep_rate;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic win_close;
    logic beat;
    logic div_done;
    logic out_free;
  } sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_HIST,
    ST_PREP,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_PUSH
  } ctrl_state_e;

endpackage

// ----- src/pulse_beat_rate_detector_core.sv -----
// Pulse beat rate detector, top level.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries timestamped pulse
// sensor samples; each transfer adds the sample to the current window unless its count is full.
// Output channel (out_valid_o/out_ready_i/out_data_o) carries one result per
// closed window: smoothed level, rising flag, beat flag and the heart rate in
// tenths of bpm (zero when no beat).
// A sample that keeps the window open is only evaluated. A closing sample
// goes on to the mean division, the history update and, when it flags a beat,
// the rate division: both use one shared restoring divider that retires one
// quotient bit per cycle; the smoothed level is a reciprocal multiply.
// Results sit in an output register, so the next sample is taken while a
// result waits; if the receiver stalls and a second result is ready, the block
// holds it and takes no further sample until the register frees up.
// Reset clears all window, history and beat state and sets window_ms to 20
// and rise_limit to 4. Registers sit on the APB port at 0x0 (window_ms) and
// 0x4 (rise_limit); write them only while the block is idle.
// Depends on pbrd_pkg, pbrd_ctrl, pbrd_datapath and pbrd_divider.
module pulse_beat_rate_detector_core
  import pbrd_pkg::*;
#(
  parameter int unsigned AVG_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // registers are word aligned, paddr[2] picks one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ms  <= WIN_MS_RESET;
      cfg_q.rise_limit <= RISE_LIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WINDOW_MS:  cfg_q.window_ms  <= pwdata[WIN_MS_W-1:0];
        REG_RISE_LIMIT: cfg_q.rise_limit <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_MS:  prdata = 32'(cfg_q.window_ms);
      REG_RISE_LIMIT: prdata = 32'(cfg_q.rise_limit);
      default:        prdata = '0;
    endcase
  end

  pbrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbrd_datapath #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- src/pbrd_divider.sv -----
// pbrd_divider: restoring divider, one quotient bit per cycle
// depends on pbrd_pkg for widths
module pbrd_divider
  import pbrd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_D_W-1:0] rem_q,  rem_d;
  logic [DIV_N_W-1:0] quo_q,  quo_d;
  logic [DIV_D_W-1:0] dsr_q;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  always_comb begin
    trial = {rem_q, quo_q[DIV_N_W-1]};
    fits  = (trial >= {1'b0, dsr_q});
    if (fits) begin
      rem_d = DIV_D_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[DIV_D_W-1:0];
    end
    quo_d = {quo_q[DIV_N_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/pbrd_datapath.sv -----
// pbrd_datapath: window accumulation, history ring, beat logic, output register
// depends on pbrd_pkg and pbrd_divider
module pbrd_datapath
  import pbrd_pkg::*;
#(
  parameter int unsigned AVG_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  cmd_t      cmd_i,
  output sts_t      sts_o
);

  localparam int unsigned PTR_W = $clog2(AVG_DEPTH);
  localparam int unsigned SUM_W = MEAN_W + $clog2(AVG_DEPTH);

  // level = hsum / AVG_DEPTH as a multiply by a rounded-up reciprocal, exact over SUM_W bits
  localparam int unsigned RCP_S  = SUM_W + $clog2(AVG_DEPTH);
  localparam int unsigned PROD_W = SUM_W + RCP_S;
  localparam logic [RCP_S-1:0] RCP_M =
    RCP_S'(((64'd1 << RCP_S) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  // window state
  logic                win_open_q;
  logic [TIME_W-1:0]   win_start_q;
  logic [WSUM_W-1:0]   win_sum_q;
  logic [WCNT_W-1:0]   win_cnt_q;
  logic                close_q;
  logic [TIME_W-1:0]   now_q;

  // history state
  logic [MEAN_W-1:0]   ring_q [AVG_DEPTH];
  logic [PTR_W-1:0]    ptr_q;
  logic [SUM_W-1:0]    hsum_q;
  logic [SUM_W-1:0]    hbase_q;
  logic [SUM_W-1:0]    prev_q;
  logic [LIMIT_W-1:0]  rise_cnt_q;
  logic                latch_q;
  logic                rising_q;
  logic                beat_q;

  // beat interval state
  logic [TIME_W-1:0]   beat_stamp_q;
  logic [TIME_W-1:0]   older_q;
  logic [TIME_W-1:0]   oldest_q;
  logic [PAIR3_W-1:0]  pair3_q;
  logic [DIV_D_W-1:0]  rate_div_q;

  logic [LEVEL_W-1:0]  level_q;
  logic [RATE_W-1:0]   rate_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  // divider hookup
  logic [DIV_N_W-1:0]  div_n;
  logic [DIV_D_W-1:0]  div_d;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_q;

  // accept-time logic
  logic [TIME_W-1:0]   start_sel;
  logic [WSUM_W-1:0]   sum_sel;
  logic [WCNT_W-1:0]   cnt_sel;
  logic [TIME_W-1:0]   elapsed;
  logic                close_now;

  // history-time logic
  logic                rising;
  logic [LIMIT_W-1:0]  rise_inc;
  logic                beat;
  logic [TIME_W-1:0]   first;
  logic [TIME_W:0]     pair;
  logic [PROD_W-1:0]   level_prod;
  logic [LEVEL_W-1:0]  level;

  always_comb begin
    start_sel = win_open_q ? win_start_q : in_data_i.time_ms;
    sum_sel   = win_open_q ? win_sum_q : '0;
    cnt_sel   = win_open_q ? win_cnt_q : '0;
    elapsed   = in_data_i.time_ms - start_sel;
    close_now = (elapsed >= TIME_W'(cfg_i.window_ms));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_open_q  <= 1'b0;
      win_start_q <= '0;
      win_sum_q   <= '0;
      win_cnt_q   <= '0;
      close_q     <= 1'b0;
      now_q       <= '0;
    end else if (cmd_i.take_in) begin
      win_open_q  <= !close_now;
      win_start_q <= start_sel;
      close_q     <= close_now;
      now_q       <= in_data_i.time_ms;
      // a full count freezes the window until it closes
      if (cnt_sel != COUNT_MAX) begin
        win_sum_q <= sum_sel + WSUM_W'(in_data_i.adc_sample);
        win_cnt_q <= cnt_sel + 1'b1;
      end else begin
        win_sum_q <= sum_sel;
        win_cnt_q <= cnt_sel;
      end
    end
  end

  // divider operand select
  always_comb begin
    case (cmd_i.div_op)
      DIV_MEAN: begin
        div_n = {win_sum_q, 6'b0};
        div_d = DIV_D_W'(win_cnt_q);
      end
      DIV_RATE: begin
        div_n = RATE_NUM;
        div_d = rate_div_q;
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  pbrd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    rising     = (hsum_q > prev_q);
    rise_inc   = (rise_cnt_q != RISE_MAX) ? rise_cnt_q + 1'b1 : rise_cnt_q;
    beat       = rising && !latch_q && (rise_inc > cfg_i.rise_limit);
    first      = now_q - beat_stamp_q;
    pair       = {1'b0, older_q} + {1'b0, oldest_q};
    level_prod = PROD_W'(hsum_q) * PROD_W'(RCP_M);
    level      = level_prod[RCP_S +: LEVEL_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      ptr_q        <= '0;
      hsum_q       <= '0;
      hbase_q      <= '0;
      prev_q       <= '0;
      rise_cnt_q   <= '0;
      latch_q      <= 1'b0;
      rising_q     <= 1'b0;
      beat_q       <= 1'b0;
      beat_stamp_q <= '0;
      older_q      <= '0;
      oldest_q     <= '0;
      pair3_q      <= '0;
      rate_div_q   <= '0;
      level_q      <= '0;
      rate_q       <= '0;
    end else begin
      // drop the entry about to be replaced while the mean is divided
      if (cmd_i.div_start && cmd_i.div_op == DIV_MEAN) begin
        hbase_q <= hsum_q - SUM_W'(ring_q[ptr_q]);
      end
      if (div_done) begin
        case (cmd_i.div_op)
          DIV_MEAN: begin
            ring_q[ptr_q] <= div_q[MEAN_W-1:0];
            hsum_q        <= hbase_q + SUM_W'(div_q[MEAN_W-1:0]);
          end
          DIV_RATE: begin
            if (rate_div_q == '0) begin
              rate_q <= '0;
            end else if (div_q > DIV_N_W'(RATE_MAX)) begin
              rate_q <= RATE_MAX;
            end else begin
              rate_q <= div_q[RATE_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.hist_upd) begin
        rising_q <= rising;
        beat_q   <= beat;
        rate_q   <= '0;
        level_q  <= level;
        prev_q   <= hsum_q;
        ptr_q    <= (ptr_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
        if (rising) begin
          rise_cnt_q <= rise_inc;
        end else begin
          rise_cnt_q <= '0;
          latch_q    <= 1'b0;
        end
        if (beat) begin
          latch_q      <= 1'b1;
          beat_stamp_q <= now_q;
          older_q      <= first;
          oldest_q     <= older_q;
          rate_div_q   <= DIV_D_W'({first, 2'b0}) + DIV_D_W'(pair3_q);
        end
      end
      // 3 * (older + oldest) ready for the next beat
      if (cmd_i.prep_rate) begin
        pair3_q <= PAIR3_W'({pair, 1'b0}) + PAIR3_W'(pair);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q.smoothed_level  <= level_q;
      out_data_q.curve_rising    <= rising_q;
      out_data_q.beat_found      <= beat_q;
      out_data_q.rate_tenths_bpm <= rate_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.win_close = close_q;
  assign sts_o.beat      = beat_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ----- src/pbrd_ctrl.sv -----
// pbrd_ctrl: sequencing state machine for the pulse beat rate detector
// depends on pbrd_pkg for the state, command and status types
module pbrd_ctrl
  import pbrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{take_in: 1'b0, div_start: 1'b0, div_op: DIV_MEAN,
                   hist_upd: 1'b0, prep_rate: 1'b0, load_out: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = sts_i.win_close ? ST_MEAN_GO : ST_IDLE;
      end
      ST_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_MEAN;
        state_d         = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        cmd_o.div_op = DIV_MEAN;
        if (sts_i.div_done) begin
          state_d = ST_HIST;
        end
      end
      ST_HIST: begin
        cmd_o.hist_upd = 1'b1;
        state_d        = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep_rate = 1'b1;
        state_d         = sts_i.beat ? ST_RATE_GO : ST_PUSH;
      end
      ST_RATE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RATE;
        state_d         = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        cmd_o.div_op = DIV_RATE;
        if (sts_i.div_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
